// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the LCS length engine RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, off while rst_ni is low.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clk_i out of reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/lcse_pkg.sv =====
// Package of the LCS length engine: sizes, op codes and the control structs
// passed between the top level and the dynamic-programming core. No dependencies.
package lcse_pkg;

  localparam int unsigned MAX_LEN   = 1024;
  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_LEN);
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2,
    OP_RESERVED      = 2'd3
  } op_e;

  typedef struct packed {
    logic                 wr_first;
    logic                 wr_second;
    logic [IDX_W-1:0]     wr_addr;
    logic [ELEM_BITS-1:0] wr_data;
    logic                 start;
    logic [LEN_W-1:0]     first_len;
    logic [LEN_W-1:0]     second_len;
  } core_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] lcs_len;
  } core_rsp_t;

endpackage

// ===== rtl/core/lcse_if.sv =====
// Valid/ready channel interfaces of the LCS length engine.
// Depends on nothing; field widths follow the block's word formats.
interface lcse_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] element_value;

  modport source (output valid, output op, output element_value, input ready);
  modport sink   (input valid, input op, input element_value, output ready);
endinterface

interface lcse_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] lcs_length;
  logic [10:0] first_length;
  logic [10:0] second_length;
  logic        overflow;

  modport source (output valid, output lcs_length, output first_length,
                  output second_length, output overflow, input ready);
  modport sink   (input valid, input lcs_length, input first_length,
                  input second_length, input overflow, output ready);
endinterface

// ===== rtl/core/lcs_length_engine_top.sv =====
// Channel     Dir  Fields                                            Accepted when
// in_i        in   op, element_value                                 valid && ready
// out_o       out  lcs_length, first_length, second_length, overflow valid && ready
//
// A load word is accepted back to back while idle.
// In a compute word each DP cell is a read step and a compare/max/write step of the
// single row memory port, and each row starts with a read of its first-sequence element.
// An empty pair skips the DP pass. Reset needs no clearing pass.
// The result waits in the output register; loads for the next pair go on meanwhile.
// Depends on lcse_pkg, lcse_if, lcse_core and assert_macros.svh.
`include "assert_macros.svh"

module lcs_length_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcse_in_if.sink    in_i,
  lcse_out_if.source out_o
);
  import lcse_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] first_cnt_q, first_cnt_d, second_cnt_q, second_cnt_d;
  logic             dropped_q, dropped_d;
  logic             out_valid_q, out_valid_d;
  logic [LEN_W-1:0] res_first_q, res_second_q, res_lcs_q;
  logic             res_ovf_q;
  logic [LEN_W-1:0] out_lcs_q, out_first_q, out_second_q;
  logic             out_ovf_q;
  logic             accept, load_out;

  core_req_t core_req;
  core_rsp_t core_rsp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d             = state_q;
    first_cnt_d         = first_cnt_q;
    second_cnt_d        = second_cnt_q;
    dropped_d           = dropped_q;
    core_req.wr_first   = 1'b0;
    core_req.wr_second  = 1'b0;
    core_req.wr_addr    = '0;
    core_req.wr_data    = in_i.element_value[ELEM_BITS-1:0];
    core_req.start      = 1'b0;
    core_req.first_len  = first_cnt_q;
    core_req.second_len = second_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(in_i.op))
            OP_APPEND_FIRST: begin
              if (first_cnt_q == LEN_W'(MAX_LEN)) begin
                dropped_d = 1'b1;
              end else begin
                core_req.wr_first = 1'b1;
                core_req.wr_addr  = first_cnt_q[IDX_W-1:0];
                first_cnt_d       = first_cnt_q + 1'b1;
              end
            end
            OP_APPEND_SECOND: begin
              if (second_cnt_q == LEN_W'(MAX_LEN)) begin
                dropped_d = 1'b1;
              end else begin
                core_req.wr_second = 1'b1;
                core_req.wr_addr   = second_cnt_q[IDX_W-1:0];
                second_cnt_d       = second_cnt_q + 1'b1;
              end
            end
            OP_COMPUTE: begin
              // Lengths and flag move to the result registers; the next pair starts clean.
              core_req.start = 1'b1;
              first_cnt_d    = '0;
              second_cnt_d   = '0;
              dropped_d      = 1'b0;
              // An empty pair is answered by the core in the start cycle itself.
              if (core_rsp.done) begin
                state_d = ST_EMIT;
              end else begin
                state_d = ST_RUN;
              end
            end
            OP_RESERVED: ;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (core_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      dropped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      dropped_q    <= dropped_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_req.start) begin
      res_first_q  <= first_cnt_q;
      res_second_q <= second_cnt_q;
      res_ovf_q    <= dropped_q;
    end
    if (core_rsp.done) begin
      res_lcs_q <= core_rsp.lcs_len;
    end
    if (load_out) begin
      out_lcs_q    <= res_lcs_q;
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
      out_ovf_q    <= res_ovf_q;
    end
  end

  lcse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (core_req),
    .rsp_o  (core_rsp)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.lcs_length    = out_lcs_q;
  assign out_o.first_length  = out_first_q;
  assign out_o.second_length = out_second_q;
  assign out_o.overflow      = out_ovf_q;

  `ASSERT_CLK(a_done_while_running, core_rsp.done |-> (state_q == ST_RUN || core_req.start),
              "core done out of turn")
  `ASSERT_NEVER(a_count_bound, first_cnt_q > LEN_W'(MAX_LEN) || second_cnt_q > LEN_W'(MAX_LEN),
                "sequence count beyond capacity")
  `ASSERT_CLK(a_lcs_bound, (core_rsp.done && state_q == ST_RUN) |->
              (core_rsp.lcs_len <= res_first_q && core_rsp.lcs_len <= res_second_q),
              "LCS longer than a sequence")

endmodule

// ===== rtl/core/lcse_core.sv =====
// Sequence stores, DP row memory and the cell sequencer of the LCS engine.
// Depends on lcse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcse_pkg::core_req_t req_i,
  output lcse_pkg::core_rsp_t rsp_o
);
  import lcse_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_AREAD  = 4'b0010,
    C_CELLRD = 4'b0100,
    C_CALC   = 4'b1000
  } cstate_e;

  logic [ELEM_BITS-1:0] first_mem  [MAX_LEN];
  logic [ELEM_BITS-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0]     row_mem    [MAX_LEN];

  logic [ELEM_BITS-1:0] first_rd_q, second_rd_q;
  logic [LEN_W-1:0]     row_rd_q;

  cstate_e          state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [LEN_W-1:0] m_q, m_d, n_q, n_d;
  logic [LEN_W-1:0] diag_q, diag_d, left_q, left_d;

  logic             row_wr;
  logic [LEN_W-1:0] up, cell_val;
  logic             last_col, last_row;

  // Stores are written only by loads; the row memory only by the cell step.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_first) begin
      first_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.wr_second) begin
      second_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (row_wr) begin
      row_mem[j_q] <= cell_val;
    end
    if (state_q == C_AREAD) begin
      first_rd_q <= first_mem[i_q];
    end
    if (state_q == C_CELLRD) begin
      second_rd_q <= second_mem[j_q];
      row_rd_q    <= row_mem[j_q];
    end
  end

  // On the first row the row memory holds stale data, so the cell above is zero.
  assign up       = (i_q == '0) ? '0 : row_rd_q;
  assign cell_val = (first_rd_q == second_rd_q) ? LEN_W'(diag_q + 1'b1)
                  : ((up > left_q) ? up : left_q);
  assign last_col = ({1'b0, j_q} == LEN_W'(n_q - 1'b1));
  assign last_row = ({1'b0, i_q} == LEN_W'(m_q - 1'b1));
  assign row_wr   = (state_q == C_CALC);

  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    m_d           = m_q;
    n_d           = n_q;
    diag_d        = diag_q;
    left_d        = left_q;
    rsp_o.done    = 1'b0;
    rsp_o.lcs_len = '0;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          m_d = req_i.first_len;
          n_d = req_i.second_len;
          i_d = '0;
          if (req_i.first_len == '0 || req_i.second_len == '0) begin
            rsp_o.done = 1'b1;
          end else begin
            state_d = C_AREAD;
          end
        end
      end
      C_AREAD: begin
        j_d     = '0;
        diag_d  = '0;
        left_d  = '0;
        state_d = C_CELLRD;
      end
      C_CELLRD: begin
        state_d = C_CALC;
      end
      C_CALC: begin
        diag_d = up;
        left_d = cell_val;
        if (last_col) begin
          if (last_row) begin
            rsp_o.done    = 1'b1;
            rsp_o.lcs_len = cell_val;
            state_d       = C_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = C_AREAD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = C_CELLRD;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q <= diag_d;
    left_q <= left_d;
  end

  `ASSERT_CLK(a_start_when_idle, req_i.start |-> state_q == C_IDLE, "start while core busy")
  `ASSERT_CLK(a_calc_after_read, state_q == C_CALC |-> $past(state_q) == C_CELLRD,
              "cell step without its read cycle")
  `ASSERT_CLK(a_col_in_range, state_q == C_CALC |-> ({1'b0, j_q} < n_q && {1'b0, i_q} < m_q),
              "cell index beyond sequence length")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of lcs_length_engine_top: random load and compute words
// are checked against a behavioral LCS predictor, with random stalls on both channels.
// Depends on lcse_pkg, lcse_in_if, lcse_out_if and the engine RTL.
module tb_top;
  import lcse_pkg::*;

  typedef struct {
    op_e         op;
    logic [31:0] value;
    int unsigned gap;
    bit          drain;
    bit          hold_rx;
  } stim_word_t;

  typedef struct packed {
    logic [10:0] lcs_len;
    logic [10:0] first_len;
    logic [10:0] second_len;
    logic        ovf;
  } lcs_result_t;

  logic clk_i;
  logic rst_ni;

  lcse_in_if  in_if ();
  lcse_out_if out_if ();

  lcs_length_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stim_word_t  pending_words[$];
  lcs_result_t expected_results[$];

  // Mirror of the held sequences and the dropped-append flag.
  logic [31:0] first_elems[$];
  logic [31:0] second_elems[$];
  bit          append_dropped;

  int unsigned gap_left;
  bit          cur_hold;
  bit          hold_rx_req;
  bit          hold_taken;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned rx_cycles;
  int unsigned mismatches;

  function automatic int unsigned lcs_of_held();
    int unsigned m;
    int unsigned n;
    int unsigned prev_row[];
    int unsigned cur_row[];
    m = first_elems.size();
    n = second_elems.size();
    prev_row = new[n + 1];
    cur_row  = new[n + 1];
    for (int i = 0; i < m; i++) begin
      cur_row[0] = 0;
      for (int j = 1; j <= n; j++) begin
        if (first_elems[i] == second_elems[j - 1]) begin
          cur_row[j] = prev_row[j - 1] + 1;
        end else begin
          cur_row[j] = (prev_row[j] > cur_row[j - 1]) ? prev_row[j] : cur_row[j - 1];
        end
      end
      prev_row = cur_row;
    end
    return prev_row[n];
  endfunction

  task automatic predict_word(op_e op, logic [31:0] value);
    lcs_result_t res;
    case (op)
      OP_APPEND_FIRST: begin
        if (first_elems.size() >= MAX_LEN) append_dropped = 1'b1;
        else first_elems = {first_elems, value};
      end
      OP_APPEND_SECOND: begin
        if (second_elems.size() >= MAX_LEN) append_dropped = 1'b1;
        else second_elems = {second_elems, value};
      end
      OP_COMPUTE: begin
        res.lcs_len    = 11'(lcs_of_held());
        res.first_len  = 11'(first_elems.size());
        res.second_len = 11'(second_elems.size());
        res.ovf        = append_dropped;
        expected_results = {expected_results, res};
        first_elems.delete();
        second_elems.delete();
        append_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_word(op_e op, logic [31:0] value, bit quiet, bit hold_rx = 1'b0);
    stim_word_t w;
    w.op      = op;
    w.value   = value;
    w.gap     = pick_gap(quiet);
    w.drain   = 1'b0;
    w.hold_rx = hold_rx;
    pending_words = {pending_words, w};
  endtask

  task automatic add_drain();
    stim_word_t w;
    w.op      = OP_RESERVED;
    w.value   = '0;
    w.gap     = 0;
    w.drain   = 1'b1;
    w.hold_rx = 1'b0;
    pending_words = {pending_words, w};
  endtask

  function automatic logic [31:0] narrow_value();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return 32'h0000_0005;
    endcase
  endfunction

  // A pair of short sequences with interleaved loads, stray reserved words
  // and now and then no compute, so the next pair piles on top of this one.
  task automatic add_short_pair(bit quiet, bit hold_rx);
    int unsigned m;
    int unsigned n;
    int unsigned fa;
    int unsigned sb;
    bit          narrow;
    logic [31:0] v;
    m = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    narrow = ($urandom_range(0, 2) != 0);
    fa = 0;
    sb = 0;
    while (fa < m || sb < n) begin
      v = narrow ? narrow_value() : $urandom;
      if ($urandom_range(0, 24) == 0) add_word(OP_RESERVED, $urandom, quiet);
      if (sb >= n || (fa < m && $urandom_range(0, 1) == 0)) begin
        add_word(OP_APPEND_FIRST, v, quiet);
        fa++;
      end else begin
        add_word(OP_APPEND_SECOND, v, quiet);
        sb++;
      end
    end
    if (hold_rx || $urandom_range(0, 19) != 0) add_word(OP_COMPUTE, $urandom, quiet, hold_rx);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: one word per handshake, idle cycles after each word as the word asks.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.op            <= 2'b00;
      in_if.element_value <= '0;
      gap_left            <= 0;
      cur_hold            <= 1'b0;
      hold_rx_req         <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_word(op_e'(in_if.op), in_if.element_value);
        if (cur_hold) hold_rx_req <= 1'b1;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left != 0) begin
          in_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_words.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (pending_words[0].drain) begin
          in_if.valid <= 1'b0;
          if (expected_results.size() == 0) void'(pending_words.pop_front());
        end else begin
          stim_word_t w;
          w = pending_words.pop_front();
          in_if.valid         <= 1'b1;
          in_if.op            <= w.op;
          in_if.element_value <= w.value;
          gap_left            <= w.gap;
          cur_hold            <= w.hold_rx;
        end
      end
    end
  end

  // Receiver ready: random stalls, quiet stretches, and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
      rx_cycles    <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_rx_req && !hold_taken) begin
        hold_taken   <= 1'b1;
        hold_left    <= 400;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_cycles[10:9] != 2'b11 && $urandom_range(0, 99) < 15) begin
        stall_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatches <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result lcs=%0d first=%0d second=%0d overflow=%0d",
                 $time, out_if.lcs_length, out_if.first_length, out_if.second_length,
                 out_if.overflow);
        mismatches <= mismatches + 1;
      end else begin
        lcs_result_t exp_res;
        exp_res = expected_results.pop_front();
        if (out_if.lcs_length !== exp_res.lcs_len ||
            out_if.first_length !== exp_res.first_len ||
            out_if.second_length !== exp_res.second_len ||
            out_if.overflow !== exp_res.ovf) begin
          $display("%0t: mismatch expected lcs=%0d first=%0d second=%0d overflow=%0d",
                   $time, exp_res.lcs_len, exp_res.first_len, exp_res.second_len,
                   exp_res.ovf);
          $display("%0t:          actual   lcs=%0d first=%0d second=%0d overflow=%0d",
                   $time, out_if.lcs_length, out_if.first_length, out_if.second_length,
                   out_if.overflow);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  initial begin
    int unsigned pair_idx;
    bit          quiet;

    // Directed: empty pairs, one side empty, extreme values, reserved words.
    add_word(OP_COMPUTE, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_APPEND_FIRST, 32'h8000_0000, 1'b0);
    add_word(OP_COMPUTE, 32'h0, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h7FFF_FFFF, 1'b0);
    add_word(OP_COMPUTE, 32'h0, 1'b0);
    add_word(OP_RESERVED, 32'hAAAA_AAAA, 1'b0);
    add_word(OP_APPEND_FIRST, 32'h0, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h0, 1'b0);
    add_word(OP_RESERVED, 32'h5555_5555, 1'b0);
    add_word(OP_COMPUTE, 32'h0, 1'b0);
    add_word(OP_APPEND_FIRST, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_APPEND_FIRST, 32'h7FFF_FFFF, 1'b0);
    add_word(OP_APPEND_FIRST, 32'h8000_0000, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h8000_0000, 1'b0);
    add_word(OP_APPEND_SECOND, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h7FFF_FFFF, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h5555_5555, 1'b0);
    add_word(OP_COMPUTE, 32'h0, 1'b0);
    add_word(OP_APPEND_FIRST, 32'h1234_5678, 1'b0);
    add_word(OP_APPEND_SECOND, 32'h1234_5679, 1'b0);
    add_word(OP_COMPUTE, 32'h0, 1'b0);
    add_drain();

    pair_idx = 0;
    while (pending_words.size() < 1400) begin
      // A burst of back-to-back pairs follows the word that starts the long hold-off.
      quiet = (pair_idx >= 8 && pair_idx < 13) || (pair_idx % 16 == 5);
      if (pair_idx == 20) begin
        // First sequence runs past its capacity; the extra appends are dropped.
        for (int i = 0; i < MAX_LEN + 6; i++) add_word(OP_APPEND_FIRST, 32'(i % 7), 1'b1);
        for (int i = 0; i < 3; i++) add_word(OP_APPEND_SECOND, 32'(i * 2), 1'b0);
        add_word(OP_COMPUTE, 32'h0, 1'b0);
      end else begin
        add_short_pair(quiet, pair_idx == 8);
      end
      if (pair_idx == 15) add_drain();
      pair_idx++;
    end

    wait (rst_ni === 1'b1);
    do @(posedge clk_i); while (pending_words.size() != 0 || in_if.valid);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("lcs_length_engine_top verification clean");
    end else begin
      $display("lcs_length_engine_top verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("lcs_length_engine_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lcse_pkg.sv
rtl/core/lcse_if.sv
rtl/core/lcse_core.sv
rtl/core/lcs_length_engine_top.sv
verif/tb_top.sv
